[design/assert_macros.svh]
// Assertion macros for the checker file of this block.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, ignored while reset is held low
`define SVBP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, including during reset
`define SVBP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/svbp_pkg.sv]
// Shared types and constants for the status variable block parser.
// No dependencies; used by svbp_core and status_var_block_parser.
package svbp_pkg;

    // Parser phase within the status variable block
    typedef enum logic [2:0] {
        PH_CODE   = 3'd0,
        PH_SKIP   = 3'd1,
        PH_LEN    = 3'd2,
        PH_CS0    = 3'd3,
        PH_CS1    = 3'd4,
        PH_CSREST = 3'd5,
        PH_IGNORE = 3'd6
    } phase_t;

    // Status variable codes
    localparam logic [7:0] CODE_FLAGS2        = 8'd0;
    localparam logic [7:0] CODE_SQL_MODE      = 8'd1;
    localparam logic [7:0] CODE_AUTO_INCR     = 8'd3;
    localparam logic [7:0] CODE_CHARSET       = 8'd4;
    localparam logic [7:0] CODE_TIME_ZONE     = 8'd5;
    localparam logic [7:0] CODE_CATALOG       = 8'd6;
    localparam logic [7:0] CODE_LC_TIME_NAMES = 8'd7;
    localparam logic [7:0] CODE_CHARSET_DB    = 8'd8;
    localparam logic [7:0] CODE_TABLE_MAP     = 8'd9;
    localparam logic [7:0] CODE_MASTER_DATA   = 8'd10;

    // Value sizes of the fixed-length entries
    localparam logic [7:0] SKIP_2 = 8'd2;
    localparam logic [7:0] SKIP_4 = 8'd4;
    localparam logic [7:0] SKIP_8 = 8'd8;

    // Charset bytes left after the two id bytes
    localparam logic [7:0] CS_REST_LEN = 8'd4;

    // Result of one block, handed from the core to the output register
    typedef struct packed {
        logic        status;
        logic        charset_seen;
        logic [15:0] charset_value;
    } result_t;

endpackage

[design/status_var_block_parser.sv]
// Status variable block parser: takes one byte of a query event's status
// variable block per item and gives one result item on the item flagged as
// last. A byte can be accepted every cycle; only a last byte waits, and only
// while the previous result is still held at the output unaccepted. A result
// is registered at the output when its last byte leaves the input register.
// The byte rate is set by the state update in svbp_core, fed from an input
// register and draining into an output register.
// Depends on svbp_pkg and svbp_core.
module status_var_block_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic        m_charset_seen,
    output logic [15:0] m_charset_value
);

    logic              in_valid_reg;
    logic [7:0]        in_data_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    svbp_pkg::result_t out_reg;
    svbp_pkg::result_t core_result;
    logic              out_free;
    logic              advance;

    // Input item moves on unless it is a last byte facing a full output
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    svbp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .result    (core_result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_reg <= core_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_reg.status;
    assign m_charset_seen  = out_reg.charset_seen;
    assign m_charset_value = out_reg.charset_value;

endmodule

[design/svbp_core.sv]
// Parser state and per-byte next-state logic for the status variable block.
// Depends on svbp_pkg for the phase type, codes and result struct.
module svbp_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output svbp_pkg::result_t result
);

    svbp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       skip_reg, skip_next;
    logic [15:0]      accum_reg, accum_next;
    logic             flag_reg, flag_next;
    logic [7:0]       skip_dec;

    // Counter step, held at zero
    assign skip_dec = (skip_reg != 8'd0) ? skip_reg - 8'd1 : 8'd0;

    // Next state for one byte
    always_comb begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        accum_next = accum_reg;
        flag_next  = flag_reg;
        unique case (phase_reg)
            svbp_pkg::PH_CODE: begin
                case (data_byte) inside
                    svbp_pkg::CODE_FLAGS2, svbp_pkg::CODE_AUTO_INCR,
                    svbp_pkg::CODE_MASTER_DATA: begin
                        phase_next = svbp_pkg::PH_SKIP;
                        skip_next  = svbp_pkg::SKIP_4;
                    end
                    svbp_pkg::CODE_SQL_MODE, svbp_pkg::CODE_TABLE_MAP: begin
                        phase_next = svbp_pkg::PH_SKIP;
                        skip_next  = svbp_pkg::SKIP_8;
                    end
                    svbp_pkg::CODE_LC_TIME_NAMES, svbp_pkg::CODE_CHARSET_DB: begin
                        phase_next = svbp_pkg::PH_SKIP;
                        skip_next  = svbp_pkg::SKIP_2;
                    end
                    svbp_pkg::CODE_TIME_ZONE, svbp_pkg::CODE_CATALOG: begin
                        phase_next = svbp_pkg::PH_LEN;
                    end
                    svbp_pkg::CODE_CHARSET: begin
                        phase_next = svbp_pkg::PH_CS0;
                    end
                    default: begin
                        phase_next = svbp_pkg::PH_IGNORE;
                    end
                endcase
            end
            svbp_pkg::PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 8'd0) begin
                    phase_next = svbp_pkg::PH_CODE;
                end
            end
            svbp_pkg::PH_LEN: begin
                skip_next  = data_byte;
                phase_next = (data_byte == 8'd0) ? svbp_pkg::PH_CODE : svbp_pkg::PH_SKIP;
            end
            svbp_pkg::PH_CS0: begin
                accum_next = {8'd0, data_byte};
                phase_next = svbp_pkg::PH_CS1;
            end
            svbp_pkg::PH_CS1: begin
                accum_next = {data_byte, accum_reg[7:0]};
                skip_next  = svbp_pkg::CS_REST_LEN;
                phase_next = svbp_pkg::PH_CSREST;
            end
            svbp_pkg::PH_CSREST: begin
                skip_next = skip_dec;
                if (skip_dec == 8'd0) begin
                    flag_next  = 1'b1;
                    phase_next = svbp_pkg::PH_IGNORE;
                end
            end
            default: begin
                phase_next = svbp_pkg::PH_IGNORE;
            end
        endcase
    end

    // Result seen through the updated state
    always_comb begin
        result.status = !((phase_next == svbp_pkg::PH_CODE) ||
                          (phase_next == svbp_pkg::PH_IGNORE));
        result.charset_seen  = flag_next;
        result.charset_value = flag_next ? accum_next : 16'd0;
    end

    // State registers; back to reset state after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= svbp_pkg::PH_CODE;
            skip_reg  <= 8'd0;
            accum_reg <= 16'd0;
            flag_reg  <= 1'b0;
        end else if (step_en) begin
            if (last_byte) begin
                phase_reg <= svbp_pkg::PH_CODE;
                skip_reg  <= 8'd0;
                accum_reg <= 16'd0;
                flag_reg  <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                skip_reg  <= skip_next;
                accum_reg <= accum_next;
                flag_reg  <= flag_next;
            end
        end
    end

endmodule

[design/svbp_checker.sv]
// Port-level checks for the status variable block parser, bound to the top.
// Depends on assert_macros.svh and status_var_block_parser.
`include "assert_macros.svh"

module svbp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_status,
    input logic        m_charset_seen,
    input logic [15:0] m_charset_value
);

    // No result item straight after reset
    `SVBP_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // A stalled result holds
    `SVBP_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_charset_value), "stalled result changed")

    // Charset id is zero unless a full charset entry was found
    `SVBP_ASSERT(a_cs_zero, aclk, aresetn, m_valid && !m_charset_seen |-> m_charset_value == 16'd0, "charset value without entry")

    // A complete charset entry ends parsing, so the block cannot be truncated
    `SVBP_ASSERT(a_cs_ok, aclk, aresetn, m_valid && m_charset_seen |-> !m_status, "truncated after charset")

endmodule

bind status_var_block_parser svbp_checker u_svbp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_charset_seen  (m_charset_seen),
    .m_charset_value (m_charset_value)
);

[dv/status_var_block_parser_test.sv]
// Self-checking testbench for status_var_block_parser: drives status variable blocks
// byte by byte and checks every block result against an in-bench predictor.
// Depends on svbp_pkg and the status_var_block_parser RTL.
`timescale 1ns / 1ps

module status_var_block_parser_test;

    localparam int ITEM_TARGET  = 1250;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_DIRECTED   = 23;

    // Tracks the parser state per byte and holds the block results still owed
    class block_result_board;
        svbp_pkg::phase_t  phase;
        logic [7:0]        skip_left;
        logic [15:0]       cs_id;
        logic              cs_done;
        svbp_pkg::result_t pending_results[$];
        int                bytes_taken;
        int                blocks_checked;
        int                truncated_blocks;
        int                charset_blocks;
        int                errors;

        function new();
            clear();
            bytes_taken      = 0;
            blocks_checked   = 0;
            truncated_blocks = 0;
            charset_blocks   = 0;
            errors           = 0;
        endfunction

        function void clear();
            phase     = svbp_pkg::PH_CODE;
            skip_left = 8'd0;
            cs_id     = 16'd0;
            cs_done   = 1'b0;
        endfunction

        // Advance the parser on one accepted byte; a last byte owes a result
        function void take_byte(logic [7:0] b, logic lst);
            svbp_pkg::result_t r;
            bytes_taken++;
            case (phase)
                svbp_pkg::PH_CODE: begin
                    case (b) inside
                        svbp_pkg::CODE_FLAGS2, svbp_pkg::CODE_AUTO_INCR,
                        svbp_pkg::CODE_MASTER_DATA: begin
                            phase = svbp_pkg::PH_SKIP;
                            skip_left = svbp_pkg::SKIP_4;
                        end
                        svbp_pkg::CODE_SQL_MODE, svbp_pkg::CODE_TABLE_MAP: begin
                            phase = svbp_pkg::PH_SKIP;
                            skip_left = svbp_pkg::SKIP_8;
                        end
                        svbp_pkg::CODE_LC_TIME_NAMES, svbp_pkg::CODE_CHARSET_DB: begin
                            phase = svbp_pkg::PH_SKIP;
                            skip_left = svbp_pkg::SKIP_2;
                        end
                        svbp_pkg::CODE_TIME_ZONE, svbp_pkg::CODE_CATALOG:
                            phase = svbp_pkg::PH_LEN;
                        svbp_pkg::CODE_CHARSET: phase = svbp_pkg::PH_CS0;
                        default: phase = svbp_pkg::PH_IGNORE;
                    endcase
                end
                svbp_pkg::PH_SKIP: begin
                    if (skip_left != 8'd0) skip_left = skip_left - 8'd1;
                    if (skip_left == 8'd0) phase = svbp_pkg::PH_CODE;
                end
                svbp_pkg::PH_LEN: begin
                    skip_left = b;
                    phase = (b == 8'd0) ? svbp_pkg::PH_CODE : svbp_pkg::PH_SKIP;
                end
                svbp_pkg::PH_CS0: begin
                    cs_id = {8'd0, b};
                    phase = svbp_pkg::PH_CS1;
                end
                svbp_pkg::PH_CS1: begin
                    cs_id = {b, cs_id[7:0]};
                    skip_left = svbp_pkg::CS_REST_LEN;
                    phase = svbp_pkg::PH_CSREST;
                end
                svbp_pkg::PH_CSREST: begin
                    if (skip_left != 8'd0) skip_left = skip_left - 8'd1;
                    if (skip_left == 8'd0) begin
                        cs_done = 1'b1;
                        phase = svbp_pkg::PH_IGNORE;
                    end
                end
                default: phase = svbp_pkg::PH_IGNORE;
            endcase
            if (lst) begin
                r.status        = !(phase == svbp_pkg::PH_CODE ||
                                    phase == svbp_pkg::PH_IGNORE);
                r.charset_seen  = cs_done;
                r.charset_value = cs_done ? cs_id : 16'd0;
                pending_results = {pending_results, r};
                clear();
            end
        endfunction

        // Compare one accepted result item with the oldest owed result
        function void check_block_result(logic st, logic seen, logic [15:0] val);
            svbp_pkg::result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d seen %0d %s %h",
                         $time, st, seen, "value", val);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            blocks_checked++;
            if (want.status) truncated_blocks++;
            if (want.charset_seen) charset_blocks++;
            if (st !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, st);
                errors++;
            end
            if (seen !== want.charset_seen) begin
                $display("%0t: charset_seen expected %0d got %0d",
                         $time, want.charset_seen, seen);
                errors++;
            end
            if (val !== want.charset_value) begin
                $display("%0t: charset_value expected %h got %h",
                         $time, want.charset_value, val);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_status;
    logic        m_charset_seen;
    logic [15:0] m_charset_value;

    block_result_board board;
    logic [7:0]        block_bytes[$];
    logic              no_idle = 1'b0;
    int                stall_cycles = 0;
    int                blocks_sent = 0;

    // Directed blocks, {last, byte}: full charset with a trailing byte, unknown
    // code alone, valued code cut at its code byte, zero length catalog,
    // charset cut short, charset database then unknown code, one-byte time zone
    logic [8:0] directed_items[N_DIRECTED] = '{
        {1'b0, svbp_pkg::CODE_CHARSET}, 9'h0ff, 9'h0ff, 9'h000, 9'h000, 9'h000, 9'h000,
        9'h1ff,
        9'h1ff,
        {1'b1, svbp_pkg::CODE_SQL_MODE},
        {1'b0, svbp_pkg::CODE_CATALOG}, 9'h100,
        {1'b0, svbp_pkg::CODE_CHARSET}, 9'h000, 9'h180,
        {1'b0, svbp_pkg::CODE_CHARSET_DB}, 9'h001, 9'h002, 9'h00b, 9'h17f,
        {1'b0, svbp_pkg::CODE_TIME_ZONE}, 9'h001, 9'h155
    };

    status_var_block_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_charset_seen  (m_charset_seen),
        .m_charset_value (m_charset_value)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; none in a calm stretch
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (no_idle) return 0;
        if (r < 55) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= lst;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        board.take_byte(b, lst);
    endtask

    // Random block: mostly well-formed entries, some cut short, some pure noise
    task automatic build_block();
        int         entries;
        int         n;
        int         cut;
        logic [7:0] code;
        logic [7:0] len;
        block_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = int'($urandom_range(1, 12));
            repeat (n) block_bytes = {block_bytes, 8'($urandom_range(0, 255))};
            return;
        end
        entries = int'($urandom_range(1, 5));
        for (int k = 0; k < entries; k++) begin
            case ($urandom_range(0, 11))
                0:  code = svbp_pkg::CODE_FLAGS2;
                1:  code = svbp_pkg::CODE_SQL_MODE;
                2:  code = svbp_pkg::CODE_AUTO_INCR;
                3:  code = svbp_pkg::CODE_CHARSET;
                4:  code = svbp_pkg::CODE_TIME_ZONE;
                5:  code = svbp_pkg::CODE_CATALOG;
                6:  code = svbp_pkg::CODE_LC_TIME_NAMES;
                7:  code = svbp_pkg::CODE_CHARSET_DB;
                8:  code = svbp_pkg::CODE_TABLE_MAP;
                9:  code = svbp_pkg::CODE_MASTER_DATA;
                default: code = ($urandom_range(0, 3) == 0) ? 8'd2
                                                            : 8'($urandom_range(11, 255));
            endcase
            block_bytes = {block_bytes, code};
            case (code) inside
                svbp_pkg::CODE_FLAGS2, svbp_pkg::CODE_AUTO_INCR,
                svbp_pkg::CODE_MASTER_DATA:
                    n = int'(svbp_pkg::SKIP_4);
                svbp_pkg::CODE_SQL_MODE, svbp_pkg::CODE_TABLE_MAP:
                    n = int'(svbp_pkg::SKIP_8);
                svbp_pkg::CODE_LC_TIME_NAMES, svbp_pkg::CODE_CHARSET_DB:
                    n = int'(svbp_pkg::SKIP_2);
                svbp_pkg::CODE_CHARSET:
                    n = 6;
                svbp_pkg::CODE_TIME_ZONE, svbp_pkg::CODE_CATALOG: begin
                    len = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(7, 255))
                                                       : 8'($urandom_range(0, 6));
                    block_bytes = {block_bytes, len};
                    n = int'(len);
                end
                default: n = 0;
            endcase
            repeat (n) block_bytes = {block_bytes, 8'($urandom_range(0, 255))};
            // Nothing after a charset or an unknown code is parsed
            if (code == svbp_pkg::CODE_CHARSET || n == 0 && code != svbp_pkg::CODE_TIME_ZONE
                    && code != svbp_pkg::CODE_CATALOG) begin
                n = int'($urandom_range(0, 3));
                repeat (n) block_bytes = {block_bytes, 8'($urandom_range(0, 255))};
                break;
            end
        end
        if (block_bytes.size() > 1 && $urandom_range(0, 4) == 0) begin
            cut = int'($urandom_range(1, block_bytes.size() - 1));
            while (block_bytes.size() > cut) block_bytes.delete(block_bytes.size() - 1);
        end
    endtask

    // Result side back-pressure
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            n = pick_gap();
            repeat (n) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            n = int'($urandom_range(1, 12));
            repeat (n) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Result monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid && m_ready)
            board.check_block_result(m_status, m_charset_seen, m_charset_value);
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("status_var_block_parser_test: FAIL");
            $finish;
        end
    end

    initial begin
        board       = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = 8'd0;
        s_last_byte = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_byte(directed_items[i][7:0], directed_items[i][8]);
            if (directed_items[i][8]) blocks_sent++;
        end

        while (board.bytes_taken < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 5) == 0);
            build_block();
            for (int i = 0; i < block_bytes.size(); i++)
                send_byte(block_bytes[i], i == block_bytes.size() - 1);
            blocks_sent++;
        end
        no_idle = 1'b0;
        @(negedge aclk);
        s_valid <= 1'b0;

        // Let the owed results drain, then allow for the output latency
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        board.errors += board.pending_results.size();
        $display("Sent %0d blocks in %0d bytes; checked %0d results.",
                 blocks_sent, board.bytes_taken, board.blocks_checked);
        $display("Of those, %0d ended inside a value and %0d carried a charset id.",
                 board.truncated_blocks, board.charset_blocks);
        if (board.errors == 0)
            $display("status_var_block_parser_test: PASS");
        else
            $display("status_var_block_parser_test: FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/svbp_pkg.sv
design/svbp_core.sv
design/status_var_block_parser.sv
design/svbp_checker.sv
dv/status_var_block_parser_test.sv
